// File: hw/rtl/mstt_pkg.sv
// Package for the multi-slot timer table: field widths, the operation codes,
// the slot record and the control structs passed between the sub-blocks.
// No dependencies.
package mstt_pkg;

	localparam int FUNC_W       = 3;
	localparam int ID_W         = 4;
	localparam int IVAL_W       = 32;
	localparam int ELAPSED_W    = 16;
	localparam int MAX_RESULTS  = 16;
	localparam int CNT_W        = $clog2(MAX_RESULTS + 1);
	localparam int NUM_TIMERS_DEF = 16;

	typedef enum logic [FUNC_W-1:0] {
		FN_DEFINE = 3'd0,
		FN_START  = 3'd1,
		FN_STOP   = 3'd2,
		FN_RESET  = 3'd3,
		FN_TICK   = 3'd4
	} func_t;

	// One entry of the slot memory.
	typedef struct packed {
		logic              active;
		logic              periodic;
		logic [IVAL_W-1:0] interval;
		logic [IVAL_W-1:0] remaining;
	} slot_t;

	// Fire event from the sequencer to the result buffer.
	typedef struct packed {
		logic            valid;
		logic [ID_W-1:0] id;
		logic            retired;
	} fire_t;

	// Back pressure from the result buffer to the sequencer.
	typedef struct packed {
		logic push_ok;
		logic flush_ok;
	} buf_stat_t;

endpackage

// File: hw/rtl/mstt_in_if.sv
// Input channel of the timer table: one command or tick word per handshake.
// Depends on mstt_pkg.
interface mstt_in_if
	import mstt_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [FUNC_W-1:0]    func;
	logic [ID_W-1:0]      timer_id;
	logic [IVAL_W-1:0]    interval;
	logic                 periodic;
	logic [ELAPSED_W-1:0] elapsed_ms;

	modport source (output valid, func, timer_id, interval, periodic, elapsed_ms,
		input ready);
	modport sink (input valid, func, timer_id, interval, periodic, elapsed_ms,
		output ready);
endinterface

// File: hw/rtl/mstt_out_if.sv
// Result channel of the timer table: one fire word per handshake.
// Depends on mstt_pkg.
interface mstt_out_if
	import mstt_pkg::*;
();
	logic            valid;
	logic            ready;
	logic [ID_W-1:0] fired_id;
	logic            retired;
	logic            last;

	modport source (output valid, fired_id, retired, last, input ready);
	modport sink (input valid, fired_id, retired, last, output ready);
endinterface

// File: hw/rtl/mstt_slot_ram.sv
// Slot memory: one synchronous read port with registered data, one write
// port, and a valid bit per entry so that unwritten slots read as zero.
// Depends on mstt_pkg.
module mstt_slot_ram
	import mstt_pkg::*;
#(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF,
	parameter int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [IW-1:0] rd_addr,
	output slot_t         rd_data,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_addr,
	input  slot_t         wr_data
);

	slot_t mem [NUM_TIMERS];
	logic  [NUM_TIMERS-1:0] vld_q;
	slot_t rd_q;
	logic  rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// An entry never written since reset reads as the all-zero reset value.
	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

// File: hw/rtl/mstt_result_buf.sv
// Result buffer: holds one fire word back until the next one (or the end of
// the tick) shows whether it is the last, then drives the output register.
// Depends on mstt_pkg and mstt_out_if.
module mstt_result_buf
	import mstt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  fire_t      fire,
	input  logic       flush,
	output buf_stat_t  stat,
	mstt_out_if.source result
);

	logic            out_v_q;
	logic [ID_W-1:0] out_id_q;
	logic            out_ret_q;
	logic            out_last_q;
	logic            pend_v_q;
	logic [ID_W-1:0] pend_id_q;
	logic            pend_ret_q;
	logic            out_free;
	logic            do_push;
	logic            do_flush;

	assign out_free      = !out_v_q || result.ready;
	assign stat.push_ok  = !pend_v_q || out_free;
	assign stat.flush_ok = !pend_v_q || out_free;
	assign do_push       = fire.valid && stat.push_ok;
	assign do_flush      = flush && pend_v_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_v_q <= (do_push && pend_v_q) || do_flush;
			end
			if (do_push) begin
				pend_v_q <= 1'b1;
			end else if (do_flush) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((do_push && pend_v_q) || do_flush) begin
			out_id_q   <= pend_id_q;
			out_ret_q  <= pend_ret_q;
			out_last_q <= do_flush;
		end
		if (do_push) begin
			pend_id_q  <= fire.id;
			pend_ret_q <= fire.retired;
		end
	end

	assign result.valid    = out_v_q;
	assign result.fired_id = out_id_q;
	assign result.retired  = out_ret_q;
	assign result.last     = out_last_q;

endmodule

// File: hw/rtl/mstt_seq.sv
// Sequencer: takes input words, runs the read-modify-write of one slot per
// command and the slot-by-slot scan of a tick. Depends on mstt_pkg, mstt_in_if.
module mstt_seq
	import mstt_pkg::*;
#(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF,
	parameter int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	mstt_in_if.sink       item,
	output logic          rd_en,
	output logic [IW-1:0] rd_addr,
	input  slot_t         rd_data,
	output logic          wr_en,
	output logic [IW-1:0] wr_addr,
	output slot_t         wr_data,
	output fire_t         fire,
	output logic          flush,
	input  buf_stat_t     stat
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMD,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

	state_t               st_q;
	func_t                op_q;
	logic [IW-1:0]        id_q;
	logic [IVAL_W-1:0]    ival_q;
	logic                 per_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [IW-1:0]        nxt_q;
	logic                 more_q;
	logic                 s1_v_q;
	logic [IW-1:0]        idx_s1;
	logic [CNT_W-1:0]     cnt_q;

	logic              acc;
	logic              is_cmd;
	logic              id_ok;
	logic [IVAL_W-1:0] elapsed_x;
	logic [IVAL_W-1:0] rem_dec;
	logic              fire_s1;
	logic              emit_s1;
	logic              adv;
	slot_t             tick_word;
	slot_t             cmd_word;

	assign item.ready = (st_q == ST_IDLE);
	assign acc        = item.valid && item.ready;
	assign is_cmd     = (item.func == FN_DEFINE) || (item.func == FN_START) ||
		(item.func == FN_STOP) || (item.func == FN_RESET);
	assign id_ok      = 32'(item.timer_id) < 32'(NUM_TIMERS);

	// Tick update of the slot whose data has just come back from memory.
	assign elapsed_x = IVAL_W'(elapsed_q);
	assign rem_dec   = (rd_data.remaining < elapsed_x) ? '0 : rd_data.remaining - elapsed_x;
	assign fire_s1   = s1_v_q && rd_data.active && (rem_dec == '0);
	assign emit_s1   = fire_s1 && (cnt_q < CNT_W'(MAX_RESULTS));
	assign adv       = !s1_v_q || !emit_s1 || stat.push_ok;

	always_comb begin
		tick_word = rd_data;
		tick_word.remaining = rem_dec;
		if (fire_s1) begin
			if (rd_data.periodic) begin
				tick_word.remaining = rd_data.interval;
			end else begin
				tick_word.active = 1'b0;
			end
		end
	end

	always_comb begin
		cmd_word = rd_data;
		case (op_q)
			FN_DEFINE: begin
				cmd_word.interval  = ival_q;
				cmd_word.remaining = ival_q;
				cmd_word.periodic  = per_q;
				cmd_word.active    = 1'b0;
			end
			FN_START: begin
				cmd_word.active = 1'b1;
			end
			FN_STOP: begin
				cmd_word.active = 1'b0;
			end
			FN_RESET: begin
				cmd_word.interval  = ival_q;
				cmd_word.remaining = ival_q;
				cmd_word.active    = 1'b1;
			end
			default: begin
				cmd_word = rd_data;
			end
		endcase
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = nxt_q;
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = tick_word;
		flush   = 1'b0;
		case (st_q)
			ST_IDLE: begin
				rd_en   = acc && is_cmd && id_ok;
				rd_addr = IW'(item.timer_id);
			end
			ST_CMD: begin
				wr_en   = 1'b1;
				wr_addr = id_q;
				wr_data = cmd_word;
			end
			ST_SCAN: begin
				rd_en = adv && more_q;
				wr_en = s1_v_q && adv && rd_data.active;
			end
			ST_FLUSH: begin
				flush = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	assign fire.valid   = (st_q == ST_SCAN) && emit_s1;
	assign fire.id      = ID_W'(idx_s1);
	assign fire.retired = !rd_data.periodic;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			op_q      <= FN_DEFINE;
			id_q      <= '0;
			ival_q    <= '0;
			per_q     <= 1'b0;
			elapsed_q <= '0;
			nxt_q     <= '0;
			more_q    <= 1'b0;
			s1_v_q    <= 1'b0;
			idx_s1    <= '0;
			cnt_q     <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (acc) begin
						op_q      <= func_t'(item.func);
						id_q      <= IW'(item.timer_id);
						ival_q    <= item.interval;
						per_q     <= item.periodic;
						elapsed_q <= item.elapsed_ms;
						if (item.func == FN_TICK) begin
							st_q   <= ST_SCAN;
							nxt_q  <= '0;
							more_q <= 1'b1;
							s1_v_q <= 1'b0;
							cnt_q  <= '0;
						end else if (is_cmd && id_ok) begin
							st_q <= ST_CMD;
						end
					end
				end
				ST_CMD: begin
					st_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (adv) begin
						s1_v_q <= more_q;
						idx_s1 <= nxt_q;
						if (more_q) begin
							if (nxt_q == LAST_IDX) begin
								more_q <= 1'b0;
							end else begin
								nxt_q <= nxt_q + 1'b1;
							end
						end else begin
							st_q <= ST_FLUSH;
						end
						if (emit_s1) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (stat.flush_ok) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/multi_slot_timer_table_unit.sv
// Top level of the multi-slot timer table: slot memory, sequencer and
// result buffer. Depends on mstt_pkg, mstt_in_if, mstt_out_if and the
// mstt_slot_ram, mstt_result_buf and mstt_seq modules.
//
// Usage: the item channel takes one word per handshake. A word either edits
// one timer slot (define, start, stop, reset with a new interval) or is a
// tick that advances every active slot by elapsed_ms. A tick produces one
// result word for each active slot that reaches zero, up to MAX_RESULTS, in
// ascending slot order, last set on the final one; other words produce nothing.
//
// Operation: a slot edit is a read of the slot memory followed by a write,
// after which the block is ready again. A tick streams the slot memory at
// one slot per cycle through its single read port, pausing while the
// result buffer cannot take a firing slot's result. Words with an unknown
// function or a slot id beyond the table are accepted and change nothing.
//
// Reset clears the control state and the per-slot valid bits; every slot
// then reads as zero (inactive, one-shot, zero interval) with no clearing
// pass, so the block takes words right after reset. When the result
// receiver stalls, the output register and one held-back result fill up and
// the tick scan pauses on the slot that fires next; a stall drops no result.
module multi_slot_timer_table_unit
	import mstt_pkg::*;
#(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mstt_in_if.sink    item,
	mstt_out_if.source result
);

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	logic          rd_en;
	logic [IW-1:0] rd_addr;
	slot_t         rd_data;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	slot_t         wr_data;
	fire_t         fire;
	logic          flush;
	buf_stat_t     stat;

	// Slot state: interval, remaining time and flags, one entry per timer.
	mstt_slot_ram #(
		.NUM_TIMERS(NUM_TIMERS),
		.IW        (IW)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	// Command decode, slot edits and the tick scan.
	mstt_seq #(
		.NUM_TIMERS(NUM_TIMERS),
		.IW        (IW)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.fire   (fire),
		.flush  (flush),
		.stat   (stat)
	);

	// Holds one result back so that the last flag can be set correctly.
	mstt_result_buf u_buf (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.flush (flush),
		.stat  (stat),
		.result(result)
	);

endmodule
